// ----- hdl/str_esc_pkg.sv -----
package str_esc_pkg;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_BSL   = 3'd1,
    PH_OCT1  = 3'd2,
    PH_OCT2  = 3'd3,
    PH_HEX0  = 3'd4,
    PH_HEX1  = 3'd5
  } phase_e;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       end_of_literal;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       last_of_literal;
  } out_beat_t;

  typedef struct packed {
    logic [CntW-1:0]               count;
    logic [MaxBytes-1:0][7:0]      bytes;
    logic                          last;
  } group_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] held_first;
    logic [7:0] held_second;
  } esc_state_t;

endpackage

// ----- hdl/str_esc_decode.sv -----
module str_esc_decode import str_esc_pkg::*; (
  input  in_beat_t   beat_i,
  input  esc_state_t state_i,
  output esc_state_t state_o,
  output group_t     group_o
);

  localparam logic [7:0] ChBsl = 8'h5C;
  localparam logic [7:0] ChX   = 8'h78;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  logic [7:0]            c;
  logic                  last;
  logic [2:0]            d1;
  logic [2:0]            d2;
  logic                  hit;
  logic [7:0]            sval;
  logic [CntW-1:0]       cnt;
  logic [MaxBytes-1:0][7:0] byts;
  logic                  do_plain;
  esc_state_t            nxt;

  assign c    = beat_i.raw_byte;
  assign last = beat_i.end_of_literal;
  assign d1   = state_i.held_first[2:0];
  assign d2   = state_i.held_second[2:0];

  always_comb begin
    hit  = 1'b1;
    sval = 8'h00;
    case (c)
      8'h6E: sval = 8'd10;
      8'h74: sval = 8'd9;
      8'h72: sval = 8'd13;
      8'h62: sval = 8'd8;
      8'h66: sval = 8'd12;
      8'h76: sval = 8'd11;
      8'h61: sval = 8'd7;
      8'h30: sval = 8'd0;
      8'h5C: sval = 8'd92;
      8'h22: sval = 8'd34;
      8'h27: sval = 8'd39;
      8'h3F: sval = 8'd63;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    cnt       = '0;
    byts      = '0;
    do_plain  = 1'b0;
    nxt       = state_i;
    nxt.phase = PH_PLAIN;
    case (state_i.phase)
      PH_BSL: begin
        if (hit) begin
          byts[0] = sval;
          cnt     = CntW'(1);
        end else if ((c >= 8'h31) && (c <= 8'h37)) begin
          if (last) begin
            byts[0] = {5'b0, c[2:0]};
            cnt     = CntW'(1);
          end else begin
            nxt.held_first = c;
            nxt.phase      = PH_OCT1;
          end
        end else if (c == ChX) begin
          if (last) begin
            byts[0] = ChBsl;
            byts[1] = ChX;
            cnt     = CntW'(2);
          end else begin
            nxt.phase = PH_HEX0;
          end
        end else begin
          byts[0]  = ChBsl;
          cnt      = CntW'(1);
          do_plain = 1'b1;
        end
      end
      PH_OCT1: begin
        if (is_oct(c)) begin
          if (last) begin
            byts[0] = {2'b0, d1, c[2:0]};
            cnt     = CntW'(1);
          end else begin
            nxt.held_second = c;
            nxt.phase       = PH_OCT2;
          end
        end else begin
          byts[0]  = {5'b0, d1};
          cnt      = CntW'(1);
          do_plain = 1'b1;
        end
      end
      PH_OCT2: begin
        if (is_oct(c)) begin
          if (d1[2]) begin
            byts[0] = ChBsl;
            byts[1] = state_i.held_first;
            byts[2] = state_i.held_second;
            byts[3] = c;
            cnt     = CntW'(4);
          end else begin
            byts[0] = {d1[1:0], d2, c[2:0]};
            cnt     = CntW'(1);
          end
        end else begin
          byts[0]  = {2'b0, d1, d2};
          cnt      = CntW'(1);
          do_plain = 1'b1;
        end
      end
      PH_HEX0: begin
        if (is_hex(c)) begin
          if (last) begin
            byts[0] = ChBsl;
            byts[1] = ChX;
            byts[2] = c;
            cnt     = CntW'(3);
          end else begin
            nxt.held_first = c;
            nxt.phase      = PH_HEX1;
          end
        end else begin
          byts[0]  = ChBsl;
          byts[1]  = ChX;
          cnt      = CntW'(2);
          do_plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (is_hex(c)) begin
          byts[0] = {hex_val(state_i.held_first), hex_val(c)};
          cnt     = CntW'(1);
        end else begin
          byts[0]  = ChBsl;
          byts[1]  = ChX;
          byts[2]  = state_i.held_first;
          cnt      = CntW'(3);
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      if ((c == ChBsl) && !last) begin
        nxt.phase = PH_BSL;
      end else begin
        byts[cnt[IdxW-1:0]] = c;
        cnt                 = cnt + CntW'(1);
      end
    end
    if (last) begin
      nxt.phase = PH_PLAIN;
    end
  end

  assign state_o       = nxt;
  assign group_o.count = cnt;
  assign group_o.bytes = byts;
  assign group_o.last  = last;

endmodule

// ----- hdl/str_esc_emit.sv -----
module str_esc_emit import str_esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  group_t    group_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic                     valid_q, valid_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [IdxW-1:0]          top_q;
  logic                     last_q;
  logic [MaxBytes-1:0][7:0] bytes_q;
  logic                     take;
  logic                     at_end;
  logic [CntW-1:0]          top_full;

  assign take     = valid_q && !out_stall_i;
  assign at_end   = idx_q == top_q;
  assign free_o   = !valid_q || (take && at_end);
  assign top_full = group_i.count - CntW'(1);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (at_end) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= group_i.bytes;
      top_q   <= top_full[IdxW-1:0];
      last_q  <= group_i.last;
    end
  end

  assign out_valid_o                = valid_q;
  assign out_data_o.decoded_byte    = bytes_q[idx_q];
  assign out_data_o.last_of_literal = last_q && at_end;

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= top_q)
    else $error("beat index past end of group");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over undelivered beats");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> valid_q && $stable(idx_q))
    else $error("stalled beat advanced");

endmodule

// ----- hdl/string_escape_decoder_core.sv -----
// String escape decoder.
// Input channel (in_valid_i / in_stall_o / in_data_i): one raw byte of a
// string literal body per beat, end_of_literal set on its final byte.
// Output channel (out_valid_o / out_stall_i / out_data_o): decoded bytes in
// order, last_of_literal set on the final decoded byte of each literal.
// An accepted byte is held in an input register and decoded combinationally
// into a group of zero to four bytes; a non-empty group is written into the
// output register, so each result passes through both registers in turn.
// Throughput is one input beat per cycle while each beat yields at most one
// byte and the receiver does not stall; the output register sends one byte
// per cycle unless stalled, and a larger group holds the input until sent.
// Beats that only open or extend an escape yield nothing and bypass output.
// Reset clears the escape phase, the held digits and all valid flags.
// While the receiver stalls, the current output beat holds; once the input
// register also holds a beat with output, in_stall_o rises and input holds.
module string_escape_decoder_core import str_esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic       in_valid_q, in_valid_d;
  in_beat_t   in_q;
  esc_state_t state_q, state_d;
  group_t     group;
  logic       free;
  logic       consume;
  logic       accept;

  str_esc_decode u_decode (
    .beat_i  (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .group_o (group)
  );

  assign consume    = in_valid_q && ((group.count == '0) || free);
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '{phase: PH_PLAIN, held_first: 8'h00, held_second: 8'h00};
    end else begin
      in_valid_q <= in_valid_d;
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  str_esc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && (group.count != '0)),
    .group_i     (group),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_plain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_q.end_of_literal |=> state_q.phase == PH_PLAIN)
    else $error("escape pending after end of literal");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_q.end_of_literal |-> group.count != '0)
    else $error("final byte of literal produced no output");

  a_group_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> group.count <= CntW'(MaxBytes))
    else $error("decoded group too large");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(in_q))
    else $error("pending input beat lost");

endmodule

// ----- test/string_escape_decoder_checker.sv -----
module string_escape_decoder_checker import str_esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam int MaxReports = 20;

  phase_e     esc_phase;
  logic [7:0] first_digit;
  logic [7:0] second_digit;
  logic [7:0] group_bytes[$];
  out_beat_t  expected_bytes[$];
  out_beat_t  want;

  function automatic bit is_octal(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 8'd10);
    return 4'(c - "A" + 8'd10);
  endfunction

  function automatic bit simple_escape(input logic [7:0] c, output logic [7:0] value);
    value = 8'd0;
    case (c)
      "n": value = 8'd10;
      "t": value = 8'd9;
      "r": value = 8'd13;
      "b": value = 8'd8;
      "f": value = 8'd12;
      "v": value = 8'd11;
      "a": value = 8'd7;
      "0": value = 8'd0;
      "\\": value = 8'd92;
      "\"": value = 8'd34;
      "'": value = 8'd39;
      "?": value = 8'd63;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void take_plain(input logic [7:0] c, input logic last);
    if (c == "\\" && !last) begin
      esc_phase = PH_BSL;
    end else begin
      group_bytes.push_back(c);
      esc_phase = PH_PLAIN;
    end
  endfunction

  function automatic void decode_raw(input in_beat_t beat);
    logic [7:0] c;
    logic       last;
    logic [7:0] mapped;
    logic [2:0] d1;
    logic [2:0] d2;
    logic [8:0] octal_val;
    c    = beat.raw_byte;
    last = beat.end_of_literal;
    d1   = first_digit[2:0];
    d2   = second_digit[2:0];
    group_bytes.delete();
    case (esc_phase)
      PH_BSL: begin
        esc_phase = PH_PLAIN;
        if (simple_escape(c, mapped)) begin
          group_bytes.push_back(mapped);
        end else if (c >= "1" && c <= "7") begin
          if (last) begin
            group_bytes.push_back({5'd0, c[2:0]});
          end else begin
            first_digit = c;
            esc_phase   = PH_OCT1;
          end
        end else if (c == "x") begin
          if (last) begin
            group_bytes.push_back("\\");
            group_bytes.push_back("x");
          end else begin
            esc_phase = PH_HEX0;
          end
        end else begin
          group_bytes.push_back("\\");
          take_plain(c, last);
        end
      end
      PH_OCT1: begin
        esc_phase = PH_PLAIN;
        if (is_octal(c)) begin
          if (last) begin
            group_bytes.push_back({2'd0, d1, c[2:0]});
          end else begin
            second_digit = c;
            esc_phase    = PH_OCT2;
          end
        end else begin
          group_bytes.push_back({5'd0, d1});
          take_plain(c, last);
        end
      end
      PH_OCT2: begin
        esc_phase = PH_PLAIN;
        if (is_octal(c)) begin
          octal_val = {d1, d2, c[2:0]};
          if (octal_val <= 9'd255) begin
            group_bytes.push_back(octal_val[7:0]);
          end else begin
            group_bytes.push_back("\\");
            group_bytes.push_back(first_digit);
            group_bytes.push_back(second_digit);
            group_bytes.push_back(c);
          end
        end else begin
          group_bytes.push_back({2'd0, d1, d2});
          take_plain(c, last);
        end
      end
      PH_HEX0: begin
        esc_phase = PH_PLAIN;
        if (is_hex_digit(c)) begin
          if (last) begin
            group_bytes.push_back("\\");
            group_bytes.push_back("x");
            group_bytes.push_back(c);
          end else begin
            first_digit = c;
            esc_phase   = PH_HEX1;
          end
        end else begin
          group_bytes.push_back("\\");
          group_bytes.push_back("x");
          take_plain(c, last);
        end
      end
      PH_HEX1: begin
        esc_phase = PH_PLAIN;
        if (is_hex_digit(c)) begin
          group_bytes.push_back({hex_value(first_digit), hex_value(c)});
        end else begin
          group_bytes.push_back("\\");
          group_bytes.push_back("x");
          group_bytes.push_back(first_digit);
          take_plain(c, last);
        end
      end
      default: begin
        take_plain(c, last);
      end
    endcase
    if (last) esc_phase = PH_PLAIN;
    foreach (group_bytes[i]) begin
      expected_bytes.push_back(out_beat_t'{
        decoded_byte:    group_bytes[i],
        last_of_literal: last && (i == group_bytes.size() - 1)
      });
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (errors_o < MaxReports) $display("mismatch at %0t: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_phase    = PH_PLAIN;
      first_digit  = 8'd0;
      second_digit = 8'd0;
      expected_bytes.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte %02h last %b",
                                    out_data_i.decoded_byte, out_data_i.last_of_literal));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_i.decoded_byte !== want.decoded_byte)
            report_mismatch($sformatf("decoded_byte %02h, expected %02h",
                                      out_data_i.decoded_byte, want.decoded_byte));
          if (out_data_i.last_of_literal !== want.last_of_literal)
            report_mismatch($sformatf("last_of_literal %b, expected %b (byte %02h)",
                                      out_data_i.last_of_literal, want.last_of_literal,
                                      want.decoded_byte));
        end
      end
      if (in_valid_i && !in_stall_i) decode_raw(in_data_i);
      pending_o = expected_bytes.size();
    end
  end

endmodule

// ----- test/string_escape_decoder_core_tb.sv -----
module string_escape_decoder_core_tb;
  import str_esc_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 12;
  localparam int HoldOffCycles = 200;
  localparam int PhaseItems    = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  bit pressure_req = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int errors;
  int pending;

  string directed_text[6] = '{"\\n\\01", "\\377\\400", "\\78\\6", "\\12",
                              "\\xfF\\xg", "\\u\\"};

  always #(HalfPeriod) clk = ~clk;

  string_escape_decoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  string_escape_decoder_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // hold off once for a long stretch, otherwise stall at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HoldOffCycles;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("string_escape_decoder_core_tb NOT OK");
      $finish;
    end
  end

  task automatic send_beat(input in_beat_t beat);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_beat(in_beat_t'{raw_byte: text[i], end_of_literal: i == text.len() - 1});
    end
  endtask

  task automatic send_random_literal();
    logic [7:0] text[$];
    int         tokens;
    int         extra;
    string      simple_set;
    string      hex_set;
    string      odd_set;
    simple_set = "ntrbfva0\\\"'?";
    hex_set    = "0123456789abcdefABCDEF";
    odd_set    = "uUqz8";
    tokens     = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          text.push_back(8'($urandom_range(32, 126)));
        end
        2: begin
          text.push_back("\\");
          text.push_back(simple_set[$urandom_range(0, simple_set.len() - 1)]);
        end
        3: begin
          text.push_back("\\");
          text.push_back("0" + 8'($urandom_range(1, 7)));
          extra = $urandom_range(0, 1);
          repeat (extra) text.push_back("0" + 8'($urandom_range(0, 7)));
        end
        4: begin
          text.push_back("\\");
          text.push_back("0" + 8'($urandom_range(1, 7)));
          text.push_back("0" + 8'($urandom_range(0, 7)));
          text.push_back("0" + 8'($urandom_range(0, 7)));
        end
        5: begin
          text.push_back("\\");
          text.push_back("x");
          text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
          text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
        end
        6: begin
          text.push_back("\\");
          text.push_back("x");
          extra = $urandom_range(0, 1);
          repeat (extra) text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
          text.push_back(odd_set[$urandom_range(0, odd_set.len() - 1)]);
        end
        7: begin
          text.push_back("\\");
          if ($urandom_range(0, 1)) text.push_back(odd_set[$urandom_range(0, odd_set.len() - 1)]);
          else text.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          text.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          text.push_back("\\");
        end
      endcase
    end
    foreach (text[i]) begin
      send_beat(in_beat_t'{raw_byte: text[i], end_of_literal: i == text.size() - 1});
    end
    items_sent += text.size();
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_text[i]) send_text(directed_text[i]);
    send_beat(in_beat_t'{raw_byte: 8'h00, end_of_literal: 1'b0});
    send_beat(in_beat_t'{raw_byte: 8'hFF, end_of_literal: 1'b1});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          pressure_req <= 1'b1;
        end
        1: begin
          idle_pct = 72;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 72;
        end
        default: begin
          idle_pct = 15;
          stall_pct <= 15;
        end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) send_random_literal();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("string_escape_decoder_core_tb OK");
    end else begin
      $display("string_escape_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
